// ===== hw/rtl/pcbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcbc_pkg;

    localparam int COORD_W   = 12;
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 26;
    localparam int CH_W      = 3;
    localparam int ROW_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam int LIN_W     = ROW_W + COORD_W;

    localparam int MAX_CHANNELS = 4;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DST_CH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_CH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_ROW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ROW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_ALPHA = 3'd5;

    localparam logic [CH_W-1:0] CH_ONE  = 3'd1;
    localparam logic [CH_W-1:0] CH_TWO  = 3'd2;
    localparam logic [CH_W-1:0] CH_FOUR = 3'd4;

    localparam logic [BYTE_W-1:0] BYTE_FULL = 8'd255;

    // floor(n / 3) equals (n * 683) >> 11 for every n below 2046.
    localparam int GREY_SUM_W  = 10;
    localparam int GREY_RECIP  = 683;
    localparam int GREY_SHIFT  = 11;
    localparam int GREY_PROD_W = 20;

    typedef struct packed {
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [BYTE_W-1:0]  src_byte0;
        logic [BYTE_W-1:0]  src_byte1;
        logic [BYTE_W-1:0]  src_byte2;
        logic [BYTE_W-1:0]  src_byte3;
        logic [BYTE_W-1:0]  old_dst_byte0;
        logic [BYTE_W-1:0]  old_dst_byte1;
        logic [BYTE_W-1:0]  old_dst_byte2;
        logic [BYTE_W-1:0]  old_dst_byte3;
    } t_in_req;

    typedef struct packed {
        logic [ADDR_W-1:0] dest_byte_address;
        logic [ADDR_W-1:0] source_byte_address;
        logic [BYTE_W-1:0] new_dst_byte0;
        logic [BYTE_W-1:0] new_dst_byte1;
        logic [BYTE_W-1:0] new_dst_byte2;
        logic [BYTE_W-1:0] new_dst_byte3;
    } t_out_rsp;

    typedef logic [3:0][BYTE_W-1:0] t_pixel;

    // Load strobes of the three pipeline stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_stage_ctl;

    function automatic logic [CH_W-1:0] clamp_channels(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] r;
        if (c == '0) begin
            r = CH_ONE;
        end else if (c > CH_W'(MAX_CHANNELS)) begin
            r = CH_W'(MAX_CHANNELS);
        end else begin
            r = c;
        end
        return r;
    endfunction

    // Multiply a linear pixel index by a channel count of 1 to 4, modulo 2^ADDR_W.
    function automatic logic [ADDR_W-1:0] scale_by_channels(
        input logic [ADDR_W-1:0] lin,
        input logic [CH_W-1:0]   ch
    );
        logic [ADDR_W-1:0] r;
        unique case (ch)
            3'd2:    r = {lin[ADDR_W-2:0], 1'b0};
            3'd3:    r = lin + {lin[ADDR_W-2:0], 1'b0};
            3'd4:    r = {lin[ADDR_W-3:0], 2'b00};
            default: r = lin;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pcbc_addr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcbc_addr (
    input  wire logic                       i_clk,
    input  wire pcbc_pkg::t_stage_ctl       i_ctl,
    input  wire logic [pcbc_pkg::COORD_W-1:0] i_dest_x,
    input  wire logic [pcbc_pkg::COORD_W-1:0] i_dest_y,
    input  wire logic [pcbc_pkg::COORD_W-1:0] i_src_x,
    input  wire logic [pcbc_pkg::COORD_W-1:0] i_src_y,
    input  wire logic [pcbc_pkg::ROW_W-1:0] i_dst_row,
    input  wire logic [pcbc_pkg::ROW_W-1:0] i_src_row,
    input  wire logic [pcbc_pkg::CH_W-1:0]  i_dst_ch,
    input  wire logic [pcbc_pkg::CH_W-1:0]  i_src_ch,
    input  wire logic                       i_transposed,
    output logic      [pcbc_pkg::ADDR_W-1:0] o_dst_addr,
    output logic      [pcbc_pkg::ADDR_W-1:0] o_src_addr
);
    import pcbc_pkg::*;

    logic [COORD_W-1:0] n_col;
    logic [COORD_W-1:0] n_row;
    logic [LIN_W-1:0]   n_dprod;
    logic [LIN_W-1:0]   n_sprod;

    logic [LIN_W-1:0]   r_dprod;
    logic [LIN_W-1:0]   r_sprod;
    logic [COORD_W-1:0] r_dx;
    logic [COORD_W-1:0] r_col;
    logic [ADDR_W-1:0]  r_dlin;
    logic [ADDR_W-1:0]  r_slin;
    logic [ADDR_W-1:0]  r_dst_addr;
    logic [ADDR_W-1:0]  r_src_addr;

    always_comb begin
        n_col   = i_transposed ? i_src_y : i_src_x;
        n_row   = i_transposed ? i_src_x : i_src_y;
        n_dprod = LIN_W'(i_dst_row) * LIN_W'(i_dest_y);
        n_sprod = LIN_W'(i_src_row) * LIN_W'(n_row);
    end

    // Stage 1: row multiply. Stage 2: add the column. Stage 3: scale by channels.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_dprod <= n_dprod;
            r_sprod <= n_sprod;
            r_dx    <= i_dest_x;
            r_col   <= n_col;
        end
        if (i_ctl.ld2) begin
            r_dlin <= ADDR_W'(r_dprod) + ADDR_W'(r_dx);
            r_slin <= ADDR_W'(r_sprod) + ADDR_W'(r_col);
        end
        if (i_ctl.ld3) begin
            r_dst_addr <= scale_by_channels(r_dlin, i_dst_ch);
            r_src_addr <= scale_by_channels(r_slin, i_src_ch);
        end
    end

    assign o_dst_addr = r_dst_addr;
    assign o_src_addr = r_src_addr;

endmodule

`default_nettype wire

// ===== hw/rtl/pcbc_conv.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcbc_conv (
    input  wire logic                      i_clk,
    input  wire pcbc_pkg::t_stage_ctl      i_ctl,
    input  wire pcbc_pkg::t_pixel          i_src,
    input  wire pcbc_pkg::t_pixel          i_old,
    input  wire logic [pcbc_pkg::CH_W-1:0] i_dst_ch,
    input  wire logic [pcbc_pkg::CH_W-1:0] i_src_ch,
    input  wire logic                      i_luma_alpha,
    output pcbc_pkg::t_pixel               o_new
);
    import pcbc_pkg::*;

    logic [GREY_SUM_W-1:0]  r_sum;
    t_pixel                 r_src1;
    t_pixel                 r_old1;
    logic [GREY_PROD_W-1:0] n_prod;
    logic [BYTE_W-1:0]      r_grey;
    t_pixel                 r_src2;
    t_pixel                 r_old2;
    t_pixel                 n_new;
    t_pixel                 r_new;

    assign n_prod = GREY_PROD_W'(r_sum) * GREY_PROD_W'(GREY_RECIP);

    always_comb begin
        n_new = r_old2;
        if (i_dst_ch == i_src_ch) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                if (CH_W'(i) < i_dst_ch) begin
                    n_new[i] = r_src2[i];
                end
            end
        end else if (i_dst_ch <= CH_TWO) begin
            if (i_src_ch == CH_ONE) begin
                if (i_luma_alpha) begin
                    n_new[0] = BYTE_FULL;
                    n_new[1] = r_src2[0];
                end else begin
                    n_new[0] = r_src2[0];
                end
            end else if (i_src_ch == CH_TWO) begin
                // Grey with alpha into grey keeps the grey channel only.
                n_new[0] = r_src2[0];
            end else begin
                n_new[0] = r_grey;
                if (i_dst_ch == CH_TWO && i_src_ch == CH_FOUR) begin
                    n_new[1] = r_src2[3];
                end
            end
        end else begin
            if (i_src_ch == CH_TWO) begin
                n_new[0] = r_src2[0];
                n_new[1] = r_src2[0];
                n_new[2] = r_src2[0];
                if (i_dst_ch == CH_FOUR) begin
                    n_new[3] = r_src2[1];
                end
            end else if (i_src_ch == CH_ONE) begin
                if (i_dst_ch == CH_FOUR && i_luma_alpha) begin
                    n_new[0] = BYTE_FULL;
                    n_new[1] = BYTE_FULL;
                    n_new[2] = BYTE_FULL;
                    n_new[3] = r_src2[0];
                end else begin
                    n_new[0] = r_src2[0];
                    n_new[1] = r_src2[0];
                    n_new[2] = r_src2[0];
                end
            end else begin
                n_new[0] = r_src2[0];
                n_new[1] = r_src2[1];
                n_new[2] = r_src2[2];
            end
        end
    end

    // Stage 1: colour sum. Stage 2: divide by three. Stage 3: channel mapping.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_sum  <= GREY_SUM_W'(i_src[0]) + GREY_SUM_W'(i_src[1]) + GREY_SUM_W'(i_src[2]);
            r_src1 <= i_src;
            r_old1 <= i_old;
        end
        if (i_ctl.ld2) begin
            r_grey <= n_prod[GREY_SHIFT +: BYTE_W];
            r_src2 <= r_src1;
            r_old2 <= r_old1;
        end
        if (i_ctl.ld3) begin
            r_new <= n_new;
        end
    end

    assign o_new = r_new;

endmodule

`default_nettype wire

// ===== hw/rtl/pixel_channel_blit_convert.sv =====
// Channel  Direction  Handshake                    Payload
// in       request    i_in_valid / o_in_ready      i_req (t_in_req)
// out      result     o_out_valid / i_out_ready    o_rsp (t_out_rsp)
// cfg      write      i_cfg_we                     i_cfg_index, i_cfg_data
//
// Every accepted request passes through three register stages before its result is valid,
// and one request can be accepted in every cycle unless all stages are full and the output
// stalls; the stages are those of the address multiplier and the divide-by-three path.
// Reset clears the stage valid bits and loads the register reset values.
// A stall on the output holds only the stages that are full, so bubbles close up and
// nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module pixel_channel_blit_convert #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire pcbc_pkg::t_in_req             i_req,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output pcbc_pkg::t_out_rsp                 o_rsp,
    input  wire logic                          i_cfg_we,
    input  wire logic [pcbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [pcbc_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import pcbc_pkg::*;

    localparam int ROW_MAX_CODE = (1 << ROW_W) - 1;
    localparam int ROW_LIMIT_I  = (MAX_WIDTH > ROW_MAX_CODE) ? ROW_MAX_CODE : MAX_WIDTH;
    localparam int ROW_RESET_I  = (1024 > ROW_LIMIT_I) ? ROW_LIMIT_I : 1024;
    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(ROW_LIMIT_I);
    localparam logic [ROW_W-1:0] ROW_RESET = ROW_W'(ROW_RESET_I);

    logic [CH_W-1:0]  r_dst_ch;
    logic [CH_W-1:0]  r_src_ch;
    logic [ROW_W-1:0] r_dst_row;
    logic [ROW_W-1:0] r_src_row;
    logic             r_transposed;
    logic             r_luma_alpha;
    logic [ROW_W-1:0] n_row_clamped;

    logic       r_v1;
    logic       r_v2;
    logic       r_v3;
    logic       rdy1;
    logic       rdy2;
    logic       rdy3;
    t_stage_ctl ctl;

    t_pixel src_pix;
    t_pixel old_pix;
    t_pixel new_pix;
    logic [ADDR_W-1:0] dst_addr;
    logic [ADDR_W-1:0] src_addr;

    assign n_row_clamped = (i_cfg_data > ROW_LIMIT) ? ROW_LIMIT : i_cfg_data;

    // Registers hold their clamped values, which is all the datapath ever uses.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_ch     <= CH_FOUR;
            r_src_ch     <= CH_FOUR;
            r_dst_row    <= ROW_RESET;
            r_src_row    <= ROW_RESET;
            r_transposed <= 1'b0;
            r_luma_alpha <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DST_CH:     r_dst_ch     <= clamp_channels(i_cfg_data[CH_W-1:0]);
                CFG_SRC_CH:     r_src_ch     <= clamp_channels(i_cfg_data[CH_W-1:0]);
                CFG_DST_ROW:    r_dst_row    <= n_row_clamped;
                CFG_SRC_ROW:    r_src_row    <= n_row_clamped;
                CFG_TRANSPOSED: r_transposed <= i_cfg_data[0];
                CFG_LUMA_ALPHA: r_luma_alpha <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign rdy3 = !r_v3 || i_out_ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_in_ready = rdy1;

    assign ctl = {rdy1, rdy2, rdy3};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign src_pix = {i_req.src_byte3, i_req.src_byte2, i_req.src_byte1, i_req.src_byte0};
    assign old_pix = {i_req.old_dst_byte3, i_req.old_dst_byte2,
                      i_req.old_dst_byte1, i_req.old_dst_byte0};

    pcbc_addr u_addr (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_dest_x     (i_req.dest_x),
        .i_dest_y     (i_req.dest_y),
        .i_src_x      (i_req.src_x),
        .i_src_y      (i_req.src_y),
        .i_dst_row    (r_dst_row),
        .i_src_row    (r_src_row),
        .i_dst_ch     (r_dst_ch),
        .i_src_ch     (r_src_ch),
        .i_transposed (r_transposed),
        .o_dst_addr   (dst_addr),
        .o_src_addr   (src_addr)
    );

    pcbc_conv u_conv (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_src        (src_pix),
        .i_old        (old_pix),
        .i_dst_ch     (r_dst_ch),
        .i_src_ch     (r_src_ch),
        .i_luma_alpha (r_luma_alpha),
        .o_new        (new_pix)
    );

    assign o_out_valid               = r_v3;
    assign o_rsp.dest_byte_address   = dst_addr;
    assign o_rsp.source_byte_address = src_addr;
    assign o_rsp.new_dst_byte0       = new_pix[0];
    assign o_rsp.new_dst_byte1       = new_pix[1];
    assign o_rsp.new_dst_byte2       = new_pix[2];
    assign o_rsp.new_dst_byte3       = new_pix[3];

endmodule

`default_nettype wire

// ===== hw/rtl/pcbc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcbc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire pcbc_pkg::t_in_req              i_req,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire pcbc_pkg::t_out_rsp             o_rsp,
    input wire logic                           i_cfg_we,
    input wire logic [pcbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [pcbc_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import pcbc_pkg::*;

    logic in_acc;
    logic cfg_seen;

    assign in_acc   = i_in_valid && o_in_ready;
    assign cfg_seen = i_cfg_we && (i_cfg_index != '0 || i_cfg_data != '0 || i_req != '0);

    // An empty output stage never holds back a new request.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while the output stage is empty");

    // With the output ready while it moves through the later stages, an accepted request reaches the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc ##1 i_out_ready ##1 i_out_ready |=> o_out_valid)
        else $error("accepted request did not reach the output in three cycles");

    // Reset leaves no result behind.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result shown straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready && !cfg_seen |=> o_out_valid && $stable(o_rsp))
        else $error("stalled result changed or vanished");

endmodule

bind pixel_channel_blit_convert pcbc_checker u_pcbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_req       (i_req),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_rsp       (o_rsp),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pcbc_pkg::*;

    localparam int MAX_ROW      = 4096;
    localparam int PIPE_LATENCY = 4;
    localparam int RAND_PHASES  = 20;
    localparam int PHASE_ITEMS  = 25;
    localparam int HOLD_PHASE   = 2;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 200_000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_LUMA_ALPHA + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

    typedef struct packed {
        logic [CH_W-1:0]  dst_ch;
        logic [CH_W-1:0]  src_ch;
        logic [ROW_W-1:0] dst_row;
        logic [ROW_W-1:0] src_row;
        logic             transposed;
        logic             luma;
    } t_setting;

    typedef struct {
        t_setting setting;
        t_in_req  req;
        bit       typed;
        t_out_rsp rsp;
    } t_vector;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_req              i_req;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_rsp             o_rsp;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    t_setting cfg;
    t_vector  vectors[$];
    t_out_rsp expected_pixels[$];
    t_out_rsp want_rsp;

    int  phase_num = -1;
    bit  idle_on = 1'b1;
    bit  hold_armed = 1'b0;
    int  fail_count = 0;
    int  sent_count = 0;
    int  checked_count = 0;
    int  settings_used = 0;
    int  cycle_count = 0;

    pixel_channel_blit_convert #(
        .MAX_WIDTH(MAX_ROW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_req      (i_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [CH_W-1:0] fold_channels(input logic [CH_W-1:0] c);
        if (c == '0) begin
            return CH_ONE;
        end
        if (c > CH_W'(MAX_CHANNELS)) begin
            return CH_W'(MAX_CHANNELS);
        end
        return c;
    endfunction

    function automatic logic [63:0] fold_width(input logic [ROW_W-1:0] w);
        return (w > MAX_ROW) ? 64'(MAX_ROW) : 64'(w);
    endfunction

    // Converts one pixel under the current register setting.
    function automatic t_out_rsp predict_pixel(input t_in_req r);
        t_out_rsp        p;
        logic [CH_W-1:0] d;
        logic [CH_W-1:0] s;
        logic [63:0]     dw;
        logic [63:0]     sw;
        logic [63:0]     col;
        logic [63:0]     row;
        logic [7:0]      sb [4];
        logic [7:0]      nb [4];
        int              grey_sum;
        int              i;
        d = fold_channels(cfg.dst_ch);
        s = fold_channels(cfg.src_ch);
        dw = fold_width(cfg.dst_row);
        sw = fold_width(cfg.src_row);
        col = cfg.transposed ? 64'(r.src_y) : 64'(r.src_x);
        row = cfg.transposed ? 64'(r.src_x) : 64'(r.src_y);
        sb = '{r.src_byte0, r.src_byte1, r.src_byte2, r.src_byte3};
        nb = '{r.old_dst_byte0, r.old_dst_byte1, r.old_dst_byte2, r.old_dst_byte3};
        grey_sum = int'(sb[0]) + int'(sb[1]) + int'(sb[2]);
        if (d == s) begin
            for (i = 0; i < int'(d); i++) begin
                nb[i] = sb[i];
            end
        end else if (d <= CH_TWO) begin
            if (s == CH_ONE) begin
                if (cfg.luma) begin
                    nb[0] = BYTE_FULL;
                    nb[1] = sb[0];
                end else begin
                    nb[0] = sb[0];
                end
            end else if (s == CH_TWO) begin
                // Grey with alpha into plain grey keeps only the grey byte.
                nb[0] = sb[0];
            end else begin
                nb[0] = 8'(grey_sum / 3);
                if (d == CH_TWO && s == CH_FOUR) begin
                    nb[1] = sb[3];
                end
            end
        end else begin
            if (s == CH_TWO) begin
                nb[0] = sb[0];
                nb[1] = sb[0];
                nb[2] = sb[0];
                if (d == CH_FOUR) begin
                    nb[3] = sb[1];
                end
            end else if (s == CH_ONE) begin
                if (d == CH_FOUR && cfg.luma) begin
                    nb[0] = BYTE_FULL;
                    nb[1] = BYTE_FULL;
                    nb[2] = BYTE_FULL;
                    nb[3] = sb[0];
                end else begin
                    nb[0] = sb[0];
                    nb[1] = sb[0];
                    nb[2] = sb[0];
                end
            end else begin
                nb[0] = sb[0];
                nb[1] = sb[1];
                nb[2] = sb[2];
            end
        end
        p.dest_byte_address = ADDR_W'((dw * r.dest_y + r.dest_x) * d);
        p.source_byte_address = ADDR_W'((sw * row + col) * s);
        p.new_dst_byte0 = nb[0];
        p.new_dst_byte1 = nb[1];
        p.new_dst_byte2 = nb[2];
        p.new_dst_byte3 = nb[3];
        return p;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CH_W-1:0] pick_channels();
        if ($urandom_range(0, 5) == 0) begin
            return CH_W'($urandom_range(0, 7));
        end
        return CH_W'($urandom_range(1, MAX_CHANNELS));
    endfunction

    function automatic logic [ROW_W-1:0] pick_width();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ROW_W'(1);
            2: return ROW_W'(MAX_ROW);
            3: return ROW_W'($urandom_range(MAX_ROW + 1, 2 ** ROW_W - 1));
            4: return ROW_W'($urandom_range(1, 64));
            default: return ROW_W'($urandom_range(1, MAX_ROW));
        endcase
    endfunction

    function automatic t_in_req random_pixel();
        t_in_req r;
        r.dest_x = pick_coord();
        r.dest_y = pick_coord();
        r.src_x = pick_coord();
        r.src_y = pick_coord();
        r.src_byte0 = pick_byte();
        r.src_byte1 = pick_byte();
        r.src_byte2 = pick_byte();
        r.src_byte3 = pick_byte();
        r.old_dst_byte0 = pick_byte();
        r.old_dst_byte1 = pick_byte();
        r.old_dst_byte2 = pick_byte();
        r.old_dst_byte3 = pick_byte();
        return r;
    endfunction

    task automatic add_vector(input int dc, sc, dw, sw, tr, la, input int dx, dy, sx, sy,
                              input logic [31:0] src, old, input bit typed,
                              input t_out_rsp rsp);
        t_vector v;
        v.setting.dst_ch = CH_W'(dc);
        v.setting.src_ch = CH_W'(sc);
        v.setting.dst_row = ROW_W'(dw);
        v.setting.src_row = ROW_W'(sw);
        v.setting.transposed = tr[0];
        v.setting.luma = la[0];
        v.req = {COORD_W'(dx), COORD_W'(dy), COORD_W'(sx), COORD_W'(sy), src, old};
        v.typed = typed;
        v.rsp = rsp;
        vectors.push_back(v);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input t_setting s, input bit poke_spare);
        write_reg(CFG_DST_CH, CFG_DAT_W'(s.dst_ch));
        write_reg(CFG_SRC_CH, CFG_DAT_W'(s.src_ch));
        write_reg(CFG_DST_ROW, CFG_DAT_W'(s.dst_row));
        write_reg(CFG_SRC_ROW, CFG_DAT_W'(s.src_row));
        write_reg(CFG_TRANSPOSED, CFG_DAT_W'(s.transposed));
        write_reg(CFG_LUMA_ALPHA, CFG_DAT_W'(s.luma));
        // Indexes past the register list must leave the setting untouched.
        if (poke_spare) begin
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                      CFG_DAT_W'($urandom));
        end
        i_cfg_we <= 1'b0;
        cfg = s;
        settings_used++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    task automatic send_pixel(input t_in_req r, input bit typed, input t_out_rsp rsp);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req <= r;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        expected_pixels.push_back(typed ? rsp : predict_pixel(r));
        sent_count++;
    endtask

    task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            checked_count++;
            if (expected_pixels.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                want_rsp = expected_pixels.pop_front();
                check_field("dest_byte_address", want_rsp.dest_byte_address,
                            o_rsp.dest_byte_address);
                check_field("source_byte_address", want_rsp.source_byte_address,
                            o_rsp.source_byte_address);
                check_field("new_dst_byte0", want_rsp.new_dst_byte0, o_rsp.new_dst_byte0);
                check_field("new_dst_byte1", want_rsp.new_dst_byte1, o_rsp.new_dst_byte1);
                check_field("new_dst_byte2", want_rsp.new_dst_byte2, o_rsp.new_dst_byte2);
                check_field("new_dst_byte3", want_rsp.new_dst_byte3, o_rsp.new_dst_byte3);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off so that the pipeline backs up.
    initial begin : result_sink
        int gap;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_armed) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_armed = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 17);
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        t_setting s;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cfg = '{dst_ch: CH_FOUR, src_ch: CH_FOUR, dst_row: ROW_W'(1024),
                src_row: ROW_W'(1024), transposed: 1'b0, luma: 1'b0};

        // Register values after reset, then the coordinate, width and channel-count extremes.
        add_vector(4, 4, 1024, 1024, 0, 0, 0, 0, 0, 0, 32'h11223344, 32'h55667788,
                   1'b1, {26'd0, 26'd0, 32'h11223344});
        add_vector(4, 4, 4096, 4096, 0, 0, 4095, 4095, 4095, 4095, 32'hFFFFFFFF, 32'h0,
                   1'b1, {26'h3FFFFFC, 26'h3FFFFFC, 32'hFFFFFFFF});
        add_vector(4, 4, 8191, 8191, 0, 0, 4095, 4095, 4095, 4095, 32'hFFFFFFFF, 32'h0,
                   1'b1, {26'h3FFFFFC, 26'h3FFFFFC, 32'hFFFFFFFF});
        add_vector(1, 1, 0, 0, 0, 0, 4095, 4095, 4095, 4095, 32'h12345678, 32'h9ABCDEF0,
                   1'b1, {26'd4095, 26'd4095, 32'h12BCDEF0});
        add_vector(0, 0, 0, 0, 0, 0, 4095, 4095, 4095, 4095, 32'h12345678, 32'h9ABCDEF0,
                   1'b1, {26'd4095, 26'd4095, 32'h12BCDEF0});
        add_vector(7, 5, 16, 16, 0, 0, 3, 2, 1, 1, 32'hA1B2C3D4, 32'h0F1E2D3C, 1'b0, '0);
        // Every pairing of distinct destination and source channel counts, plus equal counts of one and two.
        add_vector(1, 1, 16, 16, 0, 1, 5, 5, 6, 6, 32'h7F8899AA, 32'h11111111, 1'b0, '0);
        add_vector(2, 1, 640, 320, 0, 0, 639, 479, 319, 239, 32'hC0112233, 32'h44556677,
                   1'b0, '0);
        add_vector(2, 1, 640, 320, 0, 1, 639, 479, 319, 239, 32'hC0112233, 32'h44556677,
                   1'b0, '0);
        add_vector(1, 2, 33, 17, 0, 0, 32, 7, 16, 3, 32'h5AA51234, 32'h77777777, 1'b0, '0);
        add_vector(1, 3, 100, 100, 0, 0, 99, 99, 99, 99, 32'hFFFFFF00, 32'h01020304,
                   1'b0, '0);
        add_vector(1, 3, 100, 100, 0, 0, 0, 1, 2, 3, 32'h000002FF, 32'h01020304, 1'b0, '0);
        add_vector(2, 4, 64, 64, 0, 0, 10, 20, 30, 40, 32'h102030C8, 32'hAABBCCDD, 1'b0, '0);
        add_vector(2, 3, 64, 64, 0, 0, 10, 20, 30, 40, 32'h102030C8, 32'hAABBCCDD, 1'b0, '0);
        add_vector(3, 2, 1, 1, 0, 0, 0, 4095, 0, 4095, 32'h80FF0000, 32'h01234567, 1'b0, '0);
        add_vector(4, 2, 1, 1, 0, 0, 0, 4095, 0, 4095, 32'h80FF0000, 32'h01234567, 1'b0, '0);
        add_vector(3, 1, 4096, 1, 0, 1, 1, 2, 3, 4, 32'h3C000000, 32'hDEADBEEF, 1'b0, '0);
        add_vector(4, 1, 4096, 1, 0, 1, 1, 2, 3, 4, 32'h3C000000, 32'hDEADBEEF, 1'b0, '0);
        add_vector(4, 1, 4096, 1, 0, 0, 1, 2, 3, 4, 32'h3C000000, 32'hDEADBEEF, 1'b0, '0);
        add_vector(3, 4, 2, 2048, 0, 0, 1, 1, 2047, 2047, 32'h01020304, 32'hF0E0D0C0,
                   1'b0, '0);
        add_vector(4, 3, 2048, 2, 0, 0, 1, 1, 2047, 2047, 32'h01020304, 32'hF0E0D0C0,
                   1'b0, '0);
        add_vector(1, 4, 4096, 4096, 0, 0, 4095, 0, 0, 4095, 32'hFE0102AA, 32'h5555AAAA,
                   1'b0, '0);
        add_vector(2, 2, 5, 7, 0, 0, 4, 6, 2, 3, 32'hABCDEF01, 32'h23456789, 1'b0, '0);
        // The source is read with row and column swapped.
        add_vector(3, 3, 1000, 4096, 1, 0, 7, 8, 4095, 1, 32'h112233FF, 32'h0, 1'b0, '0);
        add_vector(4, 4, 4096, 4096, 1, 1, 0, 0, 0, 4095, 32'hFFFFFFFF, 32'h0, 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (vectors[k]) begin
            if (vectors[k].setting != cfg) begin
                drain();
                apply_setting(vectors[k].setting, 1'b0);
            end
            send_pixel(vectors[k].req, vectors[k].typed, vectors[k].rsp);
        end

        for (phase_num = 0; phase_num < RAND_PHASES; phase_num++) begin
            drain();
            // The closing phase runs without any idling on either side.
            idle_on = (phase_num != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            s.dst_ch = pick_channels();
            s.src_ch = pick_channels();
            s.dst_row = pick_width();
            s.src_row = pick_width();
            s.transposed = 1'($urandom_range(0, 1));
            s.luma = 1'($urandom_range(0, 1));
            apply_setting(s, 1'($urandom_range(0, 1)));
            if (phase_num == HOLD_PHASE) begin
                hold_armed = 1'b1;
            end
            repeat (PHASE_ITEMS) send_pixel(random_pixel(), 1'b0, '0);
        end
        drain();

        $display("tb: %0d pixel requests sent (%0d directed), %0d results checked",
                 sent_count, vectors.size(), checked_count);
        $display("tb: %0d register settings applied, %0d mismatches",
                 settings_used, fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
